[design/planar_odometry_integrator_defines.svh]
// Assertion helpers for the odometry checker.
`ifndef PLANAR_ODOMETRY_INTEGRATOR_DEFINES_SVH
`define PLANAR_ODOMETRY_INTEGRATOR_DEFINES_SVH

// Check a consequence in the cycle after the antecedent.
`define POI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("odometry check failed");

// Check a consequence in the same cycle as the antecedent.
`define POI_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("odometry check failed");

`endif

[design/poi_pkg.sv]
package poi_pkg;

    // Item kinds on the input channel
    typedef enum logic [1:0] {
        KIND_VEL  = 2'd0,
        KIND_IMU  = 2'd1,
        KIND_TICK = 2'd2
    } t_kind;

    // Register select bit (paddr[2])
    localparam logic REG_IMU_MODE = 1'b0;
    localparam logic REG_PERIOD   = 1'b1;

    localparam logic [19:0] PERIOD_RST = 20'd20000;

    // Divider sizes
    localparam int DIV_W = 68;
    localparam int DEN_W = 42;
    localparam int REM_W = 43;

    // CORDIC datapath sizes
    localparam int CX_W = 44;
    localparam int Z_W  = 34;

    localparam logic [30:0] GAIN_Q30 = 31'd652032874;

    localparam logic [29:0] ATAN_TAB [24] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
        30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
        30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
        30'd166886,    30'd83443,     30'd41722,     30'd20861,
        30'd10430,     30'd5215,      30'd2608,      30'd1304,
        30'd652,       30'd326,       30'd163,       30'd81
    };

endpackage

[design/planar_odometry_integrator.sv]
// Dead-reckoning pose integrator. Velocity commands and IMU headings are taken
// without occupying the block. A tick whose elapsed time exceeds the period
// runs two passes of one shared iterative CORDIC rotator (one stage per
// cycle) and three passes of one bit-serial restoring divider (for the heading
// step or IMU turn rate and for the x and y position steps). A tick inside the
// period is dropped. The finished pose waits in an output register while new
// items are accepted.
module planar_odometry_integrator import poi_pkg::*; #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_kind,
    input  logic signed [23:0] i_cmd_vel_x,
    input  logic signed [23:0] i_cmd_vel_y,
    input  logic signed [23:0] i_cmd_turn_rate,
    input  logic [15:0]        i_imu_heading,
    input  logic [31:0]        i_time_now_us,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic [15:0]        o_heading,
    output logic signed [23:0] o_out_vel_x,
    output logic signed [23:0] o_out_vel_y,
    output logic signed [23:0] o_out_turn_rate,
    output logic signed [15:0] o_quat_z,
    output logic signed [15:0] o_quat_w,
    output logic [31:0]        o_stamp_us,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int IT_W = $clog2(CORDIC_STAGES);

    typedef enum logic [3:0] {
        S_IDLE, S_MX, S_MY, S_CLOAD, S_CFOLD, S_CITER, S_CDONE,
        S_MUL, S_DLOAD, S_DRUN, S_DFIN, S_OUT
    } t_state;

    typedef enum logic [1:0] {OP_TURN, OP_HEAD, OP_PX, OP_PY} t_op;

    t_state r_state;
    t_op    r_op;
    logic   r_quat;
    logic   r_imu_mode;
    logic [19:0] r_period;

    logic signed [31:0] r_pos_x, r_pos_y;
    logic [31:0]        r_head_acc;
    logic [15:0]        r_head_lat;
    logic signed [23:0] r_vel_x, r_vel_y, r_turn;
    logic [31:0]        r_last, r_now, r_dt;

    logic signed [65:0]     r_prod;
    logic signed [CX_W-1:0] r_cx, r_cy;
    logic signed [Z_W-1:0]  r_cz;
    logic [IT_W-1:0]        r_it;
    logic signed [27:0]     r_rx, r_ry;
    logic [REM_W-1:0]       r_rem;
    logic [DIV_W-1:0]       r_quo;
    logic [DEN_W-1:0]       r_dvs;
    logic [6:0]             r_dcnt;
    logic                   r_neg;

    logic               r_out_valid;
    logic signed [31:0] r_o_pos_x, r_o_pos_y;
    logic [15:0]        r_o_heading;
    logic signed [23:0] r_o_vel_x, r_o_vel_y, r_o_turn;
    logic signed [15:0] r_o_qz, r_o_qw;
    logic [31:0]        r_o_stamp;

    logic [31:0]            n_dt;
    logic [31:0]            n_d;
    logic signed [32:0]     n_ma, n_mb;
    logic [65:0]            n_mag;
    logic [DIV_W-1:0]       n_dvd;
    logic [DEN_W-1:0]       n_dvs;
    logic [REM_W-1:0]       n_rsh;
    logic [REM_W:0]         n_trial;
    logic signed [48:0]     n_sq, n_psum;
    logic signed [31:0]     n_pos_sat;
    logic signed [23:0]     n_turn_sat;
    logic [31:0]            n_step, n_acc;
    logic signed [CX_W-1:0] n_dx, n_dy, n_rnd_x, n_rnd_y, n_qsum_x, n_qsum_y;
    logic signed [Z_W-1:0]  n_atan;
    logic signed [28:0]     n_qw29, n_qz29;
    logic signed [15:0]     n_qw, n_qz;
    logic                   n_fold;
    logic                   n_take;

    assign n_take = i_in_valid && (r_state == S_IDLE);
    assign n_dt   = i_time_now_us - r_last;
    assign n_d    = {r_head_lat, 16'h0000} - r_head_acc;

    // Select multiplier operands
    always_comb begin
        n_ma = 33'sd0;
        n_mb = 33'sd0;
        case (r_state)
            S_MX: begin
                n_ma = 33'(r_vel_x);
                n_mb = $signed({2'b00, GAIN_Q30});
            end
            S_MY: begin
                n_ma = 33'(r_vel_y);
                n_mb = $signed({2'b00, GAIN_Q30});
            end
            default: begin
                case (r_op)
                    OP_TURN: begin
                        n_ma = 33'($signed(n_d));
                        n_mb = 33'sd15625;
                    end
                    OP_HEAD: begin
                        n_ma = 33'(r_turn);
                        n_mb = $signed({1'b0, r_dt});
                    end
                    OP_PX: begin
                        n_ma = 33'(r_rx);
                        n_mb = $signed({1'b0, r_dt});
                    end
                    default: begin
                        n_ma = 33'(r_ry);
                        n_mb = $signed({1'b0, r_dt});
                    end
                endcase
            end
        endcase
    end

    // Form the rounded dividend and divisor for the current operation
    assign n_mag = r_prod[65] ? 66'(-r_prod) : 66'(r_prod);
    always_comb begin
        case (r_op)
            OP_TURN: begin
                n_dvd = {2'b00, n_mag} + DIV_W'({r_dt, 9'd0});
                n_dvs = {r_dt, 10'd0};
            end
            OP_HEAD: begin
                n_dvd = {n_mag[55:0], 12'd0} + DIV_W'(7812);
                n_dvs = DEN_W'(15625);
            end
            default: begin
                n_dvd = {2'b00, n_mag} + DIV_W'(500000);
                n_dvs = DEN_W'(1000000);
            end
        endcase
    end

    // One restoring divider step
    assign n_rsh   = {r_rem[REM_W-2:0], r_quo[DIV_W-1]};
    assign n_trial = {1'b0, n_rsh} - {2'b00, r_dvs};

    // Apply sign to quotient, saturate positions and turn rate
    assign n_sq   = r_neg ? -$signed({1'b0, r_quo[47:0]}) : $signed({1'b0, r_quo[47:0]});
    assign n_psum = ((r_op == OP_PX) ? 49'(r_pos_x) : 49'(r_pos_y)) + n_sq;
    always_comb begin
        if (n_psum > 49'sd2147483647) begin
            n_pos_sat = 32'sh7FFFFFFF;
        end else if (n_psum < -49'sd2147483648) begin
            n_pos_sat = -32'sh80000000;
        end else begin
            n_pos_sat = n_psum[31:0];
        end
        if (n_sq > 49'sd8388607) begin
            n_turn_sat = 24'sh7FFFFF;
        end else if (n_sq < -49'sd8388608) begin
            n_turn_sat = -24'sh800000;
        end else begin
            n_turn_sat = n_sq[23:0];
        end
    end
    assign n_step = r_neg ? (32'd0 - r_quo[31:0]) : r_quo[31:0];
    assign n_acc  = r_head_acc + n_step;

    // CORDIC stage terms and rounding
    assign n_dx     = r_cy >>> r_it;
    assign n_dy     = r_cx >>> r_it;
    assign n_atan   = $signed({{(Z_W-30){1'b0}}, ATAN_TAB[5'(r_it)]});
    assign n_fold   = (r_cz > (Z_W'(1) <<< 30)) || (r_cz < -(Z_W'(1) <<< 30));
    assign n_rnd_x  = r_cx + CX_W'(32768);
    assign n_rnd_y  = r_cy + CX_W'(32768);
    assign n_qsum_x = r_cx + CX_W'(16384);
    assign n_qsum_y = r_cy + CX_W'(16384);
    assign n_qw29   = n_qsum_x[CX_W-1:15];
    assign n_qz29   = n_qsum_y[CX_W-1:15];
    always_comb begin
        if (n_qw29 > 29'sd32767) begin
            n_qw = 16'sh7FFF;
        end else if (n_qw29 < -29'sd32768) begin
            n_qw = -16'sh8000;
        end else begin
            n_qw = n_qw29[15:0];
        end
        if (n_qz29 > 29'sd32767) begin
            n_qz = 16'sh7FFF;
        end else if (n_qz29 < -29'sd32768) begin
            n_qz = -16'sh8000;
        end else begin
            n_qz = n_qz29[15:0];
        end
    end

    // Multiply every cycle; states pick up the product they need
    always_ff @(posedge i_clk) begin
        r_prod <= n_ma * n_mb;
    end

    // Sequencer, pose state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_TURN;
            r_quat      <= 1'b0;
            r_imu_mode  <= 1'b0;
            r_period    <= PERIOD_RST;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_head_acc  <= '0;
            r_head_lat  <= '0;
            r_vel_x     <= '0;
            r_vel_y     <= '0;
            r_turn      <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Take register writes
            if (psel && penable && pwrite) begin
                if (paddr[2] == REG_PERIOD) begin
                    r_period <= pwdata[19:0];
                end else begin
                    r_imu_mode <= pwdata[0];
                end
            end

            // Drop the result once its beat is taken, unless a new one loads now
            if (r_out_valid && !i_out_stall && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (n_take) begin
                        case (i_kind)
                            KIND_VEL: begin
                                r_vel_x <= i_cmd_vel_x;
                                r_vel_y <= i_cmd_vel_y;
                                r_turn  <= i_cmd_turn_rate;
                            end
                            KIND_IMU: begin
                                if (r_imu_mode) begin
                                    r_head_lat <= i_imu_heading;
                                end
                            end
                            KIND_TICK: begin
                                if (n_dt > {12'd0, r_period}) begin
                                    r_now   <= i_time_now_us;
                                    r_dt    <= n_dt;
                                    r_quat  <= 1'b0;
                                    r_state <= S_MX;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_MX: begin
                    r_state <= S_MY;
                end
                S_MY: begin
                    r_cx    <= r_prod[57:14];
                    r_state <= S_CLOAD;
                end
                S_CLOAD: begin
                    r_cy    <= r_prod[57:14];
                    r_cz    <= $signed({{2{r_head_lat[15]}}, r_head_lat, 16'h0000});
                    r_state <= S_CFOLD;
                end
                S_CFOLD: begin
                    // Fold the angle into the right half plane
                    if (n_fold) begin
                        r_cx <= -r_cx;
                        r_cy <= -r_cy;
                        r_cz <= (r_cz > 0) ? r_cz - (Z_W'(1) <<< 31)
                                           : r_cz + (Z_W'(1) <<< 31);
                    end
                    r_it    <= '0;
                    r_state <= S_CITER;
                end
                S_CITER: begin
                    if (r_cz >= 0) begin
                        r_cx <= r_cx - n_dx;
                        r_cy <= r_cy + n_dy;
                        r_cz <= r_cz - n_atan;
                    end else begin
                        r_cx <= r_cx + n_dx;
                        r_cy <= r_cy - n_dy;
                        r_cz <= r_cz + n_atan;
                    end
                    r_it <= r_it + 1'b1;
                    if (r_it == IT_W'(CORDIC_STAGES - 1)) begin
                        r_state <= S_CDONE;
                    end
                end
                S_CDONE: begin
                    if (r_quat) begin
                        r_state <= S_OUT;
                    end else begin
                        r_rx    <= n_rnd_x[CX_W-1:16];
                        r_ry    <= n_rnd_y[CX_W-1:16];
                        r_op    <= r_imu_mode ? OP_TURN : OP_HEAD;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_DLOAD;
                end
                S_DLOAD: begin
                    r_neg   <= r_prod[65];
                    r_quo   <= n_dvd;
                    r_dvs   <= n_dvs;
                    r_rem   <= '0;
                    r_dcnt  <= '0;
                    r_state <= S_DRUN;
                end
                S_DRUN: begin
                    // Shift one quotient bit in per cycle
                    if (!n_trial[REM_W]) begin
                        r_rem <= n_trial[REM_W-1:0];
                        r_quo <= {r_quo[DIV_W-2:0], 1'b1};
                    end else begin
                        r_rem <= n_rsh;
                        r_quo <= {r_quo[DIV_W-2:0], 1'b0};
                    end
                    r_dcnt <= r_dcnt + 1'b1;
                    if (r_dcnt == 7'(DIV_W - 1)) begin
                        r_state <= S_DFIN;
                    end
                end
                S_DFIN: begin
                    case (r_op)
                        OP_TURN: begin
                            r_turn     <= n_turn_sat;
                            r_head_acc <= {r_head_lat, 16'h0000};
                            r_op       <= OP_PX;
                            r_state    <= S_MUL;
                        end
                        OP_HEAD: begin
                            r_head_acc <= n_acc;
                            r_head_lat <= n_acc[31:16];
                            r_op       <= OP_PX;
                            r_state    <= S_MUL;
                        end
                        OP_PX: begin
                            r_pos_x <= n_pos_sat;
                            r_op    <= OP_PY;
                            r_state <= S_MUL;
                        end
                        default: begin
                            // Start the half-angle rotation for the quaternion
                            r_pos_y <= n_pos_sat;
                            r_cx    <= CX_W'($signed({1'b0, GAIN_Q30}));
                            r_cy    <= '0;
                            r_cz    <= $signed({3'b000, r_head_lat, 15'h0000});
                            r_quat  <= 1'b1;
                            r_state <= S_CFOLD;
                        end
                    endcase
                end
                S_OUT: begin
                    // Hold until the output register is free
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_o_pos_x   <= r_pos_x;
                        r_o_pos_y   <= r_pos_y;
                        r_o_heading <= r_head_lat;
                        r_o_vel_x   <= r_vel_x;
                        r_o_vel_y   <= r_vel_y;
                        r_o_turn    <= r_turn;
                        r_o_qz      <= n_qz;
                        r_o_qw      <= n_qw;
                        r_o_stamp   <= r_now;
                        r_last      <= r_now;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_pos_x         = r_o_pos_x;
    assign o_pos_y         = r_o_pos_y;
    assign o_heading       = r_o_heading;
    assign o_out_vel_x     = r_o_vel_x;
    assign o_out_vel_y     = r_o_vel_y;
    assign o_out_turn_rate = r_o_turn;
    assign o_quat_z        = r_o_qz;
    assign o_quat_w        = r_o_qw;
    assign o_stamp_us      = r_o_stamp;

    // Register readback
    assign prdata = (paddr[2] == REG_PERIOD) ? {12'd0, r_period} : {31'd0, r_imu_mode};
    assign pready = 1'b1;

endmodule

[design/poi_checker.sv]
`include "planar_odometry_integrator_defines.svh"

module poi_checker import poi_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic [1:0]  i_kind,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_stamp_us
);

    // Hold a stalled result beat
    `POI_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)
    `POI_ASSERT_NEXT(a_stamp_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_stamp_us))

    // Commands and IMU beats never occupy the block
    `POI_ASSERT_NEXT(a_cmd_single, i_clk, i_rst_n,
        i_in_valid && !o_in_stall && (i_kind != KIND_TICK), !o_in_stall)

    // A result only appears at the end of a busy update
    `POI_ASSERT_SAME(a_out_after_busy, i_clk, i_rst_n, $rose(o_out_valid), $past(o_in_stall))

endmodule

bind planar_odometry_integrator poi_checker u_poi_checker (.*);

[tb/tb_planar_odometry_integrator.sv]
module tb_planar_odometry_integrator;
    timeunit 1ns;
    timeprecision 1ps;
    import poi_pkg::*;

    localparam int STAGES = 16;
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam logic [19:0] PERIOD_MAX = 20'hFFFFF;
    localparam int SETTLE_CYCLES = 2 * STAGES + 260;

    typedef struct {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [15:0] heading;
        logic [23:0] vel_x;
        logic [23:0] vel_y;
        logic [23:0] turn_rate;
        logic [15:0] quat_z;
        logic [15:0] quat_w;
        logic [31:0] stamp;
    } t_pose;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         kind = KIND_VEL;
    logic signed [23:0] cmd_vel_x = '0;
    logic signed [23:0] cmd_vel_y = '0;
    logic signed [23:0] cmd_turn_rate = '0;
    logic [15:0]        imu_heading = '0;
    logic [31:0]        time_now_us = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [31:0] pos_x, pos_y;
    logic [15:0]        heading;
    logic signed [23:0] vel_x, vel_y, turn_rate;
    logic signed [15:0] quat_z, quat_w;
    logic [31:0]        stamp_us;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    planar_odometry_integrator #(.CORDIC_STAGES(STAGES)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_kind(kind), .i_cmd_vel_x(cmd_vel_x), .i_cmd_vel_y(cmd_vel_y),
        .i_cmd_turn_rate(cmd_turn_rate), .i_imu_heading(imu_heading),
        .i_time_now_us(time_now_us),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_pos_x(pos_x), .o_pos_y(pos_y), .o_heading(heading),
        .o_out_vel_x(vel_x), .o_out_vel_y(vel_y), .o_out_turn_rate(turn_rate),
        .o_quat_z(quat_z), .o_quat_w(quat_w), .o_stamp_us(stamp_us),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Predicted odometry state and registers
    bit          mdl_imu_mode;
    bit [19:0]   mdl_period;
    longint      mdl_pos_x, mdl_pos_y;
    bit [31:0]   mdl_hdg_acc;
    bit [15:0]   mdl_hdg;
    longint      mdl_vx, mdl_vy, mdl_rate;
    bit [31:0]   mdl_last_us;

    t_pose       pending_poses[$];
    int          mismatches = 0;
    bit          idle_en = 1'b1;
    bit          hold_req = 1'b0;
    bit [31:0]   clock_us = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Divide with rounding half away from zero, divisor positive
    function automatic longint div_round(longint n, longint d);
        longint m;
        longint q;
        m = (n < 0) ? -n : n;
        q = (m + d / 2) / d;
        return (n < 0) ? -q : q;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Rotate (x,y) by an angle in 2^-32 turns, iterative shift-add
    task automatic rotate(inout longint x, inout longint y, input bit [31:0] ang);
        longint z;
        longint dx;
        longint dy;
        z = longint'(ang);
        if (z >= 64'sh80000000) z = z - 64'sh100000000;
        if (z > 64'sh40000000 || z < -64'sh40000000) begin
            x = -x;
            y = -y;
            z = (z > 0) ? z - 64'sh80000000 : z + 64'sh80000000;
        end
        for (int i = 0; i < STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
            end else begin
                x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
            end
        end
    endtask

    // Advance the pose for one accepted beat and queue the pose it emits
    task automatic integrate_beat(logic [1:0] k, logic signed [23:0] vx,
                                  logic signed [23:0] vy, logic signed [23:0] tr,
                                  logic [15:0] hd, logic [31:0] now);
        bit [31:0] dt;
        bit [31:0] target;
        longint rx, ry, qx, qy, d, p, m, step;
        t_pose pose;
        if (k == KIND_VEL) begin
            mdl_vx = vx; mdl_vy = vy; mdl_rate = tr;
            return;
        end
        if (k == KIND_IMU) begin
            if (mdl_imu_mode) mdl_hdg = hd;
            return;
        end
        if (k != KIND_TICK) return;
        dt = now - mdl_last_us;
        if (dt <= {12'd0, mdl_period}) return;

        rx = (mdl_vx * longint'(GAIN_Q30)) >>> 14;
        ry = (mdl_vy * longint'(GAIN_Q30)) >>> 14;
        rotate(rx, ry, {mdl_hdg, 16'd0});
        rx = (rx + 32768) >>> 16;
        ry = (ry + 32768) >>> 16;

        if (mdl_imu_mode) begin
            target = {mdl_hdg, 16'd0};
            d = longint'(signed'(target - mdl_hdg_acc));
            mdl_rate = clamp(div_round(d * 15625, longint'(dt) * 1024),
                             -8388608, 8388607);
            mdl_hdg_acc = target;
        end else begin
            p = mdl_rate * longint'(dt);
            m = (p < 0) ? -p : p;
            step = (m / 15625) * 4096 + ((m % 15625) * 4096 + 7812) / 15625;
            if (p < 0) step = -step;
            mdl_hdg_acc = mdl_hdg_acc + step[31:0];
            mdl_hdg = mdl_hdg_acc[31:16];
        end

        mdl_pos_x = clamp(mdl_pos_x + div_round(rx * longint'(dt), 1000000),
                          -64'sd2147483648, 64'sd2147483647);
        mdl_pos_y = clamp(mdl_pos_y + div_round(ry * longint'(dt), 1000000),
                          -64'sd2147483648, 64'sd2147483647);
        mdl_last_us = now;

        qx = longint'(GAIN_Q30);
        qy = 0;
        rotate(qx, qy, {1'b0, mdl_hdg, 15'd0});
        qx = clamp((qx + 16384) >>> 15, -32768, 32767);
        qy = clamp((qy + 16384) >>> 15, -32768, 32767);

        pose.pos_x = mdl_pos_x[31:0];
        pose.pos_y = mdl_pos_y[31:0];
        pose.heading = mdl_hdg;
        pose.vel_x = mdl_vx[23:0];
        pose.vel_y = mdl_vy[23:0];
        pose.turn_rate = mdl_rate[23:0];
        pose.quat_z = qy[15:0];
        pose.quat_w = qx[15:0];
        pose.stamp = now;
        pending_poses.push_back(pose);
    endtask

    // Offer one beat, optionally after a gap, and hold it until taken
    task automatic send_beat(logic [1:0] k, logic signed [23:0] vx,
                             logic signed [23:0] vy, logic signed [23:0] tr,
                             logic [15:0] hd, logic [31:0] now);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        kind <= k;
        cmd_vel_x <= vx;
        cmd_vel_y <= vy;
        cmd_turn_rate <= tr;
        imu_heading <= hd;
        time_now_us <= now;
        in_valid <= 1'b1;
        do @(posedge i_clk); while (in_stall);
        integrate_beat(k, vx, vy, tr, hd, now);
    endtask

    task automatic send_vel(logic signed [23:0] vx, logic signed [23:0] vy,
                            logic signed [23:0] tr);
        send_beat(KIND_VEL, vx, vy, tr, 16'($urandom), $urandom);
    endtask

    task automatic send_imu(logic [15:0] hd);
        send_beat(KIND_IMU, 24'($urandom), 24'($urandom), 24'($urandom), hd, $urandom);
    endtask

    task automatic send_tick(logic [31:0] now);
        send_beat(KIND_TICK, 24'($urandom), 24'($urandom), 24'($urandom),
                  16'($urandom), now);
    endtask

    // Drop valid, wait for all poses and let a dropped tick settle
    task automatic drain();
        int guard;
        in_valid <= 1'b0;
        guard = 0;
        while (pending_poses.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register write through the APB setup and access phases
    task automatic write_reg(logic sel, logic [31:0] value);
        drain();
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {sel, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (sel == REG_IMU_MODE) mdl_imu_mode = value[0];
        else mdl_period = value[19:0];
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %h, got %h", name, want, got);
        end
    endtask

    // Compare each pose beat
    always @(posedge i_clk) begin
        t_pose want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (pending_poses.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("mismatch: pose beat with none expected");
            end else begin
                want = pending_poses.pop_front();
                check_field("pos_x", want.pos_x, $unsigned(pos_x));
                check_field("pos_y", want.pos_y, $unsigned(pos_y));
                check_field("heading", want.heading, heading);
                check_field("out_vel_x", want.vel_x, $unsigned(vel_x));
                check_field("out_vel_y", want.vel_y, $unsigned(vel_y));
                check_field("out_turn_rate", want.turn_rate, $unsigned(turn_rate));
                check_field("quat_z", want.quat_z, $unsigned(quat_z));
                check_field("quat_w", want.quat_w, $unsigned(quat_w));
                check_field("stamp_us", want.stamp, stamp_us);
            end
        end
    end

    // Drive receiver stall: random bursts and one long hold
    int stall_burst = 0;
    int hold_cycles = 0;
    always @(posedge i_clk) begin
        if (hold_req && hold_cycles == 0) begin
            hold_cycles = 4000;
            hold_req = 1'b0;
        end
        if (hold_cycles > 0) begin
            hold_cycles--;
            out_stall <= 1'b1;
        end else if (stall_burst > 0) begin
            stall_burst--;
            out_stall <= 1'b1;
        end else if (idle_en && $urandom_range(0, 5) == 0) begin
            stall_burst = $urandom_range(1, 18) - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Turn-rate integration: extremes, dropped ticks, saturation, wrap
    task automatic test_rate_mode();
        send_vel(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
        send_tick(32'd20000);
        send_tick(32'd20001);
        send_beat(KIND_UNUSED, 24'sh123456, 24'sh654321, 24'sh7FFFFF, 16'hFFFF,
                  32'hFFFFFFFF);
        send_imu(16'hFFFF);
        send_tick(32'h80000000);
        send_vel(24'sh800000, 24'sh800000, 24'sh800000);
        send_tick(32'hFFFFFFFF);
        send_tick(32'h00000000);
        send_vel(24'sh000000, 24'sh000000, 24'sh000000);
        send_tick(32'h00100000);
        write_reg(REG_PERIOD, 32'd0);
        send_tick(32'h00100000);
        send_tick(32'h00100001);
        send_vel(-24'sd65536, 24'sd65536, -24'sd1000);
        send_tick(32'h00200000);
        write_reg(REG_PERIOD, {12'd0, PERIOD_MAX});
        send_tick(32'h00200000 + 32'd1048575);
        send_tick(32'h00200000 + 32'd1048576);
    endtask

    // IMU heading mode: wrap, half turn, saturating turn rate
    task automatic test_imu_mode();
        write_reg(REG_IMU_MODE, 32'd1);
        send_imu(16'hFFFF);
        send_tick(32'h00400000);
        send_imu(16'h8000);
        send_tick(32'h00600000);
        write_reg(REG_PERIOD, 32'd0);
        send_imu(16'h0000);
        send_tick(32'h00600001);
        send_imu(16'h7FFF);
        send_tick(32'h00600002);
        clock_us = 32'h00600002;
    endtask

    // Random beats over a sweep of register settings
    task automatic test_random(int phases, int per_phase);
        int r;
        for (int ph = 0; ph < phases; ph++) begin
            r = $urandom_range(0, 5);
            write_reg(REG_IMU_MODE, {31'd0, 1'($urandom)});
            if (r == 0) write_reg(REG_PERIOD, 32'd0);
            else if (r == 1) write_reg(REG_PERIOD, {12'd0, PERIOD_MAX});
            else if (r == 2) write_reg(REG_PERIOD, 32'd1000000);
            else write_reg(REG_PERIOD, $urandom_range(0, 3000));
            for (int n = 0; n < per_phase; n++) begin
                r = $urandom_range(0, 99);
                if (r < 25) begin
                    send_vel(24'($urandom), 24'($urandom), 24'($urandom));
                end else if (r < 45) begin
                    send_imu(16'($urandom));
                end else if (r < 95) begin
                    r = $urandom_range(0, 9);
                    if (r == 0) clock_us = $urandom;
                    else if (r < 3) clock_us += $urandom_range(0, mdl_period);
                    else clock_us += mdl_period + $urandom_range(1, 5000);
                    send_tick(clock_us);
                end else begin
                    send_beat(KIND_UNUSED, 24'($urandom), 24'($urandom), 24'($urandom),
                              16'($urandom), $urandom);
                end
            end
        end
    endtask

    // Long receiver hold while ticks keep coming
    task automatic test_backpressure();
        write_reg(REG_PERIOD, 32'd100);
        hold_req = 1'b1;
        for (int n = 0; n < 30; n++) begin
            if (n % 3 == 0) send_vel(24'($urandom), 24'($urandom), 24'($urandom));
            clock_us += 32'd101 + $urandom_range(0, 500);
            send_tick(clock_us);
        end
    endtask

    // Full rate: no gaps and no stalls
    task automatic test_full_rate();
        drain();
        idle_en = 1'b0;
        test_random(1, 60);
    endtask

    initial begin
        mdl_imu_mode = 1'b0;
        mdl_period = PERIOD_RST;
        mdl_pos_x = 0; mdl_pos_y = 0;
        mdl_hdg_acc = 0; mdl_hdg = 0;
        mdl_vx = 0; mdl_vy = 0; mdl_rate = 0;
        mdl_last_us = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_rate_mode();
        test_imu_mode();
        test_random(5, 55);
        test_backpressure();
        test_random(1, 40);
        test_full_rate();
        drain();
        if (mismatches == 0 && pending_poses.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("simulation failed");
        $finish;
    end

endmodule

[filelist.f]
+incdir+design
design/poi_pkg.sv
design/planar_odometry_integrator.sv
design/poi_checker.sv
tb/tb_planar_odometry_integrator.sv
